// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/ddm_pkg.sv -----
// types and constants of the differential drive mixer
package ddm_pkg;

    localparam int ISC_W      = 15;
    localparam int OSC_W      = 12;
    localparam int GAIN_W     = 10;
    localparam int DSC_W      = 9;
    localparam int RSI_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam int CMD_W    = 2;
    localparam int REQ_W    = 16;
    localparam int ACC_IN_W = 4;
    localparam int ACC_W    = 3;
    localparam int CAUSE_W  = 2;

    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 12;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int MIX_W   = 27;
    localparam int WK_W    = 25;

    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 24;
    localparam int QUOT_W    = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [ISC_W-1:0]  ISC_RESET  = 15'd100;
    localparam logic [OSC_W-1:0]  OSC_RESET  = 12'd400;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd256;
    localparam logic [DSC_W-1:0]  DSC_ONE    = 9'd256;
    localparam logic [RSI_W-1:0]  RSI_RESET  = 16'd100;
    localparam logic [ACC_W-1:0]  ACCEL_MAX  = 3'd4;
    localparam logic [ACC_W-1:0]  ACCEL_RESET = 3'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_TARGETS,
        CMD_TICK,
        CMD_FORCE_STOP,
        CMD_CLEAR_STOP
    } cmd_t;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_TARGETS,
        CAUSE_CHANGE,
        CAUSE_KEEPALIVE,
        CAUSE_STOP
    } cause_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_SCALE,
        CFG_OUTPUT_SCALE,
        CFG_TURN_GAIN,
        CFG_DRIVE_SCALE,
        CFG_RESEND_INTERVAL,
        CFG_MOTORS_ACTIVE,
        CFG_MODERN_MODE
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_WK,
        ST_MIX,
        ST_MUL_MIX,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_DIV_DONE,
        ST_TICK,
        ST_SCL_MUL,
        ST_SCL_DONE,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

endpackage

// ----- hw/rtl/ddm_if.sv -----
// command and frame channel interfaces
interface ddm_cmd_if;
    import ddm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [REQ_W-1:0] speed_request;
    logic signed [REQ_W-1:0] turn_request;
    logic [ACC_IN_W-1:0]     accel_request;

    modport source (
        output valid, command, speed_request, turn_request, accel_request,
        input  ready
    );
    modport sink (
        input  valid, command, speed_request, turn_request, accel_request,
        output ready
    );
endinterface

interface ddm_frame_if #(parameter int DRIVE_BITS = 13);
    import ddm_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DRIVE_BITS-1:0] left_drive;
    logic signed [DRIVE_BITS-1:0] right_drive;
    logic [ACC_W-1:0]             accel_level;
    logic [CAUSE_W-1:0]           frame_cause;

    modport source (
        output valid, left_drive, right_drive, accel_level, frame_cause,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, accel_level, frame_cause,
        output ready
    );
endinterface

// ----- hw/rtl/ddm_mul.sv -----
// shared unsigned multiplier with registered product
module ddm_mul (
    input  logic                         clk,
    input  logic [ddm_pkg::MUL_A_W-1:0]  a,
    input  logic [ddm_pkg::MUL_B_W-1:0]  b,
    output logic [ddm_pkg::PROD_W-1:0]   prod
);
    import ddm_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;
endmodule

// ----- hw/rtl/ddm_div.sv -----
// restoring divider, one quotient bit per cycle
module ddm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ddm_pkg::div_req_t req,
    output ddm_pkg::div_rsp_t rsp
);
    import ddm_pkg::*;

    logic [DIV_NUM_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] dsh_reg, dsh_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_NUM_W:0]   diff;
    logic                 ge;

    assign diff = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign ge   = ~diff[DIV_NUM_W];

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.num;
            dsh_next  = DIV_NUM_W'({req.den, {(QUOT_W-1){1'b0}}});
            quot_next = '0;
            cnt_next  = DIV_CNT_W'(QUOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = diff[DIV_NUM_W-1:0];
            end
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
endmodule

// ----- hw/rtl/diff_drive_mixer_keepalive_core.sv -----
// differential drive mixer with keepalive resend, top level
// set targets: two mixes through one multiplier and a 16-step divider, then two scaling
//   multiplies when the motors are active in modern mode
// the shared divider and multiplier set the rate; one command word is in work at a time
// a finished frame waits in the output register while the next command is taken
// reset is asynchronous active low and loads the register defaults and initial state
module diff_drive_mixer_keepalive_core #(
    parameter int DRIVE_BITS = 13
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [ddm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    ddm_cmd_if.sink                        cmd_ch,
    ddm_frame_if.source                    frame_ch
);
    import ddm_pkg::*;

    localparam int MAG_W = DRIVE_BITS - 1;
    localparam logic [QUOT_W-1:0] DRIVE_MAX = QUOT_W'((1 << MAG_W) - 1);

    function automatic logic signed [REQ_W-1:0] clamp_req(
        input logic signed [REQ_W-1:0] x,
        input logic [ISC_W-1:0]        lim
    );
        logic signed [REQ_W:0] xs;
        logic signed [REQ_W:0] hi;
        logic signed [REQ_W:0] lo;
        logic signed [REQ_W:0] r;
        xs = {x[REQ_W-1], x};
        hi = {2'b00, lim};
        lo = -hi;
        if (xs > hi)
        begin
            r = hi;
        end
        else if (xs < lo)
        begin
            r = lo;
        end
        else
        begin
            r = xs;
        end
        return r[REQ_W-1:0];
    endfunction

    // configuration
    logic [ISC_W-1:0]  isc_reg;
    logic [OSC_W-1:0]  osc_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [DSC_W-1:0]  dsc_reg;
    logic [RSI_W-1:0]  rsi_reg;
    logic              act_reg;
    logic              modern_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isc_reg    <= ISC_RESET;
            osc_reg    <= OSC_RESET;
            gain_reg   <= GAIN_RESET;
            dsc_reg    <= DSC_ONE;
            rsi_reg    <= RSI_RESET;
            act_reg    <= 1'b0;
            modern_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_INPUT_SCALE:     isc_reg    <= cfg_wdata[ISC_W-1:0];
                CFG_OUTPUT_SCALE:    osc_reg    <= cfg_wdata[OSC_W-1:0];
                CFG_TURN_GAIN:       gain_reg   <= cfg_wdata[GAIN_W-1:0];
                CFG_DRIVE_SCALE:     dsc_reg    <= cfg_wdata[DSC_W-1:0];
                CFG_RESEND_INTERVAL: rsi_reg    <= cfg_wdata[RSI_W-1:0];
                CFG_MOTORS_ACTIVE:   act_reg    <= cfg_wdata[0];
                CFG_MODERN_MODE:     modern_reg <= cfg_wdata[0];
                default:             ;
            endcase
        end
    end

    logic [ISC_W-1:0]  isc_eff;
    logic [DSC_W-1:0]  dsc_eff;
    logic [QUOT_W-1:0] lim;

    assign isc_eff = (isc_reg == '0) ? ISC_W'(1) : isc_reg;
    assign dsc_eff = (dsc_reg > DSC_ONE) ? DSC_ONE : dsc_reg;
    assign lim     = (QUOT_W'(osc_reg) > DRIVE_MAX) ? DRIVE_MAX : QUOT_W'(osc_reg);

    // sequencer state
    state_t                       state_reg, state_next;
    cmd_t                         cmd_reg, cmd_next;
    logic                         side_reg, side_next;
    logic signed [REQ_W-1:0]      vc_reg, vc_next;
    logic                         wneg_reg, wneg_next;
    logic [ISC_W-1:0]             wmag_reg, wmag_next;
    logic signed [MIX_W-1:0]      dl_reg, dl_next;
    logic signed [MIX_W-1:0]      dr_reg, dr_next;
    logic signed [DRIVE_BITS-1:0] tl_reg, tl_next;
    logic signed [DRIVE_BITS-1:0] tr_reg, tr_next;
    logic [ACC_W-1:0]             ta_reg, ta_next;
    logic signed [DRIVE_BITS-1:0] sl_reg, sl_next;
    logic signed [DRIVE_BITS-1:0] sr_reg, sr_next;
    logic signed [DRIVE_BITS-1:0] scl_l_reg, scl_l_next;
    logic signed [DRIVE_BITS-1:0] scl_r_reg, scl_r_next;
    logic                         stop_reg, stop_next;
    logic [RSI_W-1:0]             ms_reg, ms_next;
    logic signed [DRIVE_BITS-1:0] em_l_reg, em_l_next;
    logic signed [DRIVE_BITS-1:0] em_r_reg, em_r_next;
    logic [ACC_W-1:0]             em_a_reg, em_a_next;
    cause_t                       em_c_reg, em_c_next;
    logic                         out_vld_reg, out_vld_next;
    logic signed [DRIVE_BITS-1:0] out_l_reg, out_l_next;
    logic signed [DRIVE_BITS-1:0] out_r_reg, out_r_next;
    logic [ACC_W-1:0]             out_a_reg, out_a_next;
    cause_t                       out_c_reg, out_c_next;

    // shared units
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    ddm_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ddm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // datapath helpers
    logic signed [REQ_W-1:0]      v_clamp, w_clamp;
    logic [REQ_W-1:0]             w_abs;
    logic [ACC_W-1:0]             a_clamp;
    logic signed [MIX_W-1:0]      dsel, dabs, wk_pos, wk_s, v256;
    logic signed [DRIVE_BITS-1:0] tsel, tabs;
    logic [QUOT_W-1:0]            q_clamp;
    logic                         dneg;
    logic [QUOT_W:0]              t_wide;
    logic signed [DRIVE_BITS-1:0] t_val;
    logic [PROD_W-1:0]            rnd;
    logic [MAG_W-1:0]             smag;
    logic signed [DRIVE_BITS-1:0] s_val;
    logic                         changed, due, load_out;

    assign v_clamp = clamp_req(cmd_ch.speed_request, isc_eff);
    assign w_clamp = clamp_req(cmd_ch.turn_request, isc_eff);
    assign w_abs   = w_clamp[REQ_W-1] ? REQ_W'(-w_clamp) : REQ_W'(w_clamp);
    assign a_clamp = (cmd_ch.accel_request > ACC_IN_W'(ACCEL_MAX)) ? ACCEL_MAX
                                                                   : cmd_ch.accel_request[ACC_W-1:0];

    assign dsel = side_reg ? dr_reg : dl_reg;
    assign dabs = dsel[MIX_W-1] ? -dsel : dsel;
    assign tsel = side_reg ? tr_reg : tl_reg;
    assign tabs = tsel[DRIVE_BITS-1] ? -tsel : tsel;

    assign wk_pos = MIX_W'(prod[WK_W-1:0]);
    assign wk_s   = wneg_reg ? -wk_pos : wk_pos;
    assign v256   = {{(MIX_W-REQ_W-8){vc_reg[REQ_W-1]}}, vc_reg, 8'b0};

    assign q_clamp = (div_rsp.quot > lim) ? lim : div_rsp.quot;
    assign dneg    = dsel[MIX_W-1];
    assign t_wide  = dneg ? -{1'b0, q_clamp} : {1'b0, q_clamp};
    assign t_val   = t_wide[DRIVE_BITS-1:0];

    // round half away from zero over 256
    assign rnd   = prod + PROD_W'(128);
    assign smag  = rnd[8 +: MAG_W];
    assign s_val = tsel[DRIVE_BITS-1] ? -DRIVE_BITS'({1'b0, smag}) : DRIVE_BITS'({1'b0, smag});

    assign changed  = (scl_l_reg != sl_reg) || (scl_r_reg != sr_reg);
    assign due      = (ms_reg >= rsi_reg);
    assign load_out = (state_reg == ST_EMIT) && (!out_vld_reg || frame_ch.ready);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_WK:
            begin
                mul_a = MUL_A_W'(wmag_reg);
                mul_b = MUL_B_W'(gain_reg);
            end
            ST_MUL_MIX:
            begin
                mul_a = dabs[MUL_A_W-1:0];
                mul_b = MUL_B_W'(osc_reg);
            end
            ST_SCL_MUL:
            begin
                mul_a = MUL_A_W'(tabs[MAG_W-1:0]);
                mul_b = MUL_B_W'(dsc_eff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_req.start = (state_reg == ST_DIV_LOAD);
    assign div_req.num   = DIV_NUM_W'({prod, 1'b0}) + DIV_NUM_W'({isc_eff, 8'b0});
    assign div_req.den   = {isc_eff, 9'b0};

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        side_next    = side_reg;
        vc_next      = vc_reg;
        wneg_next    = wneg_reg;
        wmag_next    = wmag_reg;
        dl_next      = dl_reg;
        dr_next      = dr_reg;
        tl_next      = tl_reg;
        tr_next      = tr_reg;
        ta_next      = ta_reg;
        sl_next      = sl_reg;
        sr_next      = sr_reg;
        scl_l_next   = scl_l_reg;
        scl_r_next   = scl_r_reg;
        stop_next    = stop_reg;
        ms_next      = ms_reg;
        em_l_next    = em_l_reg;
        em_r_next    = em_r_reg;
        em_a_next    = em_a_reg;
        em_c_next    = em_c_reg;
        out_vld_next = out_vld_reg && !frame_ch.ready;
        out_l_next   = out_l_reg;
        out_r_next   = out_r_reg;
        out_a_next   = out_a_reg;
        out_c_next   = out_c_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_ch.valid)
                begin
                    unique case (cmd_t'(cmd_ch.command))
                        CMD_SET_TARGETS:
                        begin
                            cmd_next   = CMD_SET_TARGETS;
                            vc_next    = v_clamp;
                            wneg_next  = w_clamp[REQ_W-1];
                            wmag_next  = w_abs[ISC_W-1:0];
                            ta_next    = a_clamp;
                            state_next = ST_MUL_WK;
                        end
                        CMD_TICK:
                        begin
                            cmd_next   = CMD_TICK;
                            if (ms_reg != '1)
                            begin
                                ms_next = ms_reg + RSI_W'(1);
                            end
                            state_next = ST_TICK;
                        end
                        CMD_FORCE_STOP:
                        begin
                            stop_next  = 1'b1;
                            sl_next    = '0;
                            sr_next    = '0;
                            em_l_next  = '0;
                            em_r_next  = '0;
                            em_a_next  = '0;
                            em_c_next  = CAUSE_STOP;
                            state_next = ST_EMIT;
                        end
                        CMD_CLEAR_STOP:
                        begin
                            stop_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_MUL_WK:
            begin
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                dl_next    = v256 - wk_s;
                dr_next    = v256 + wk_s;
                side_next  = 1'b0;
                state_next = ST_MUL_MIX;
            end
            ST_MUL_MIX:
            begin
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE:
            begin
                if (!side_reg)
                begin
                    tl_next    = t_val;
                    side_next  = 1'b1;
                    state_next = ST_MUL_MIX;
                end
                else
                begin
                    tr_next = t_val;
                    if (act_reg && modern_reg)
                    begin
                        side_next  = 1'b0;
                        state_next = ST_SCL_MUL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TICK:
            begin
                if (!act_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (stop_reg)
                begin
                    if (due)
                    begin
                        ms_next    = '0;
                        em_l_next  = '0;
                        em_r_next  = '0;
                        em_a_next  = '0;
                        em_c_next  = CAUSE_KEEPALIVE;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!modern_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    side_next  = 1'b0;
                    state_next = ST_SCL_MUL;
                end
            end
            ST_SCL_MUL:
            begin
                state_next = ST_SCL_DONE;
            end
            ST_SCL_DONE:
            begin
                if (!side_reg)
                begin
                    scl_l_next = s_val;
                    side_next  = 1'b1;
                    state_next = ST_SCL_MUL;
                end
                else
                begin
                    scl_r_next = s_val;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (cmd_reg == CMD_SET_TARGETS || changed)
                begin
                    sl_next    = scl_l_reg;
                    sr_next    = scl_r_reg;
                    ms_next    = '0;
                    em_l_next  = scl_l_reg;
                    em_r_next  = scl_r_reg;
                    em_a_next  = ta_reg;
                    em_c_next  = (cmd_reg == CMD_SET_TARGETS) ? CAUSE_TARGETS : CAUSE_CHANGE;
                    state_next = ST_EMIT;
                end
                else if (due)
                begin
                    ms_next    = '0;
                    em_l_next  = sl_reg;
                    em_r_next  = sr_reg;
                    em_a_next  = ta_reg;
                    em_c_next  = CAUSE_KEEPALIVE;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_vld_next = 1'b1;
                    out_l_next   = em_l_reg;
                    out_r_next   = em_r_reg;
                    out_a_next   = em_a_reg;
                    out_c_next   = em_c_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cmd_reg     <= CMD_SET_TARGETS;
            side_reg    <= 1'b0;
            tl_reg      <= '0;
            tr_reg      <= '0;
            ta_reg      <= ACCEL_RESET;
            sl_reg      <= '0;
            sr_reg      <= '0;
            stop_reg    <= 1'b0;
            ms_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            side_reg    <= side_next;
            tl_reg      <= tl_next;
            tr_reg      <= tr_next;
            ta_reg      <= ta_next;
            sl_reg      <= sl_next;
            sr_reg      <= sr_next;
            stop_reg    <= stop_next;
            ms_reg      <= ms_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vc_reg    <= vc_next;
        wneg_reg  <= wneg_next;
        wmag_reg  <= wmag_next;
        dl_reg    <= dl_next;
        dr_reg    <= dr_next;
        scl_l_reg <= scl_l_next;
        scl_r_reg <= scl_r_next;
        em_l_reg  <= em_l_next;
        em_r_reg  <= em_r_next;
        em_a_reg  <= em_a_next;
        em_c_reg  <= em_c_next;
        out_l_reg <= out_l_next;
        out_r_reg <= out_r_next;
        out_a_reg <= out_a_next;
        out_c_reg <= out_c_next;
    end

    assign cmd_ch.ready         = (state_reg == ST_IDLE);
    assign frame_ch.valid       = out_vld_reg;
    assign frame_ch.left_drive  = out_l_reg;
    assign frame_ch.right_drive = out_r_reg;
    assign frame_ch.accel_level = out_a_reg;
    assign frame_ch.frame_cause = out_c_reg;
endmodule

// ----- hw/rtl/ddm_checker.sv -----
// port-level checks of the drive mixer, bound to the top level
`include "assert_macros.svh"

module ddm_checker #(
    parameter int DRIVE_BITS = 13
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [ddm_pkg::CMD_W-1:0]      in_command,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [DRIVE_BITS-1:0]   out_left,
    input logic signed [DRIVE_BITS-1:0]   out_right,
    input logic [ddm_pkg::ACC_W-1:0]      out_accel,
    input logic [ddm_pkg::CAUSE_W-1:0]    out_cause
);
    import ddm_pkg::*;

    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "frame word dropped while stalled")
    `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_left) && $stable(out_right) && $stable(out_accel) && $stable(out_cause), "frame word changed while stalled")
    `ASSERT_CLK(a_busy_after_cmd, clk, rst_n, in_valid && in_ready && (in_command != CMD_CLEAR_STOP) |=> !in_ready, "command word taken while busy")
    `ASSERT_NEVER(a_stop_zero, clk, rst_n, out_valid && (out_cause == CAUSE_STOP) && (out_left != 0 || out_right != 0 || out_accel != 0), "stop frame not zero")
    `ASSERT_NEVER(a_accel_range, clk, rst_n, out_valid && (out_accel > ACCEL_MAX), "accel level out of range")
endmodule

bind diff_drive_mixer_keepalive_core ddm_checker #(.DRIVE_BITS(DRIVE_BITS)) u_ddm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cmd_ch.valid),
    .in_ready   (cmd_ch.ready),
    .in_command (cmd_ch.command),
    .out_valid  (frame_ch.valid),
    .out_ready  (frame_ch.ready),
    .out_left   (frame_ch.left_drive),
    .out_right  (frame_ch.right_drive),
    .out_accel  (frame_ch.accel_level),
    .out_cause  (frame_ch.frame_cause)
);
